[rtl/core/cfl_time_step_spectral_radius_defines.svh]
// Assertion macros shared by the CFL time step block
`ifndef CFL_TIME_STEP_SPECTRAL_RADIUS_DEFINES_SVH
`define CFL_TIME_STEP_SPECTRAL_RADIUS_DEFINES_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define CFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define CFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFL_ASSERT(lbl, prop, msg)
`define CFL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/cflts_pkg.sv]
// Shared codes, types and constants of the CFL time step block
package cflts_pkg;

  localparam int unsigned OP_W = 5;

  // configuration register indexes
  localparam logic [2:0] REG_CFL    = 3'd0;
  localparam logic [2:0] REG_SMOOTH = 3'd1;
  localparam logic [2:0] REG_GAMMA  = 3'd2;
  localparam logic [2:0] REG_INV_PR = 3'd3;
  localparam logic [2:0] REG_VISC   = 3'd4;

  // sequencer steps; the controller state is the step being executed
  localparam logic [OP_W-1:0] OP_IDLE = 5'd0;
  localparam logic [OP_W-1:0] OP_P1   = 5'd1;   // u * |sx|
  localparam logic [OP_W-1:0] OP_P2   = 5'd2;   // v * |sy|
  localparam logic [OP_W-1:0] OP_DOT  = 5'd3;   // signed dot, sx^2
  localparam logic [OP_W-1:0] OP_YY   = 5'd4;   // sy^2
  localparam logic [OP_W-1:0] OP_DSQ  = 5'd5;   // ds^2, start root
  localparam logic [OP_W-1:0] OP_WAIT = 5'd6;   // wait on divide/root unit
  localparam logic [OP_W-1:0] OP_CR   = 5'd7;   // c * ds
  localparam logic [OP_W-1:0] OP_SR   = 5'd8;   // convective radius
  localparam logic [OP_W-1:0] OP_VA   = 5'd9;   // k * mu
  localparam logic [OP_W-1:0] OP_VB   = 5'd10;  // a * inv_prandtl
  localparam logic [OP_W-1:0] OP_VC   = 5'd11;  // start b / rho
  localparam logic [OP_W-1:0] OP_VD   = 5'd12;  // diffusion term
  localparam logic [OP_W-1:0] OP_VQ   = 5'd13;  // dtv * q
  localparam logic [OP_W-1:0] OP_VN   = 5'd14;  // numerator, start n / area
  localparam logic [OP_W-1:0] OP_VR   = 5'd15;  // add viscous radius
  localparam logic [OP_W-1:0] OP_NUM  = 5'd16;  // cfl * area
  localparam logic [OP_W-1:0] OP_SDIV = 5'd17;  // start step divide
  localparam logic [OP_W-1:0] OP_STEP = 5'd18;  // local step
  localparam logic [OP_W-1:0] OP_GDIV = 5'd19;  // start g divide
  localparam logic [OP_W-1:0] OP_GG   = 5'd20;  // g * g
  localparam logic [OP_W-1:0] OP_GE   = 5'd21;  // e * g^2
  localparam logic [OP_W-1:0] OP_GC   = 5'd22;  // clamp coefficient
  localparam logic [OP_W-1:0] OP_FIN  = 5'd23;  // emit result

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            dir;       // 0: i direction, 1: j direction
    logic            load;      // capture an input item
    logic            ds_start;  // launch the divide/root unit
    logic            emit;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic ds_busy;
    logic visc_on;
    logic smooth_on;
  } sts_t;

endpackage

[rtl/core/cflts_divsqrt.sv]
// Shared iterative unit: 64/35 restoring divide or 64-bit integer square root
module cflts_divsqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        sqrt_mode,
  input  logic [63:0] op_a,
  input  logic [34:0] op_b,
  output logic        busy,
  output logic [63:0] res
);

  logic [6:0]  cnt;
  logic        mode;
  logic [63:0] quo;    // dividend shifting into quotient, or root remainder
  logic [34:0] rem;
  logic [34:0] dvs;
  logic [63:0] rt;
  logic [63:0] bit_r;
  logic [35:0] trial;
  logic [64:0] rb;

  always_comb begin
    trial = {rem, quo[63]};
    rb    = {1'b0, rt} + {1'b0, bit_r};
  end

  // iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= sqrt_mode ? 7'd32 : 7'd64;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // one quotient bit or one root bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mode  <= sqrt_mode;
      quo   <= op_a;
      rem   <= '0;
      dvs   <= op_b;
      rt    <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (mode) begin
        if ({1'b0, quo} >= rb) begin
          quo <= quo - rb[63:0];
          rt  <= (rt >> 1) + bit_r;
        end else begin
          rt <= rt >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        if (trial >= {1'b0, dvs}) begin
          rem <= 35'(trial - {1'b0, dvs});
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial[34:0];
          quo <= {quo[62:0], 1'b0};
        end
      end
    end
  end

  assign res = mode ? rt : quo;

endmodule

[rtl/core/cflts_datapath.sv]
// Datapath: config registers, operand registers, multiplier, divide/root unit
module cflts_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cflts_pkg::cmd_t     cmd,
  output cflts_pkg::sts_t     sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [30:0]         cfg_data,
  input  logic [319:0]        in_data,
  input  logic                in_last,
  output logic [191:0]        out_data,
  output logic                out_last,
  output logic                out_err
);

  localparam logic [63:0] ONE_FX      = 64'd1 << FRAC_BITS;
  localparam logic [30:0] FOUR_THIRDS = 31'(((64'd4 << FRAC_BITS) + 64'd1) / 64'd3);

  function automatic logic [30:0] sat31(input logic [63:0] x);
    sat31 = (x > 64'(cflts_pkg::MAX31)) ? cflts_pkg::MAX31 : x[30:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // configuration
  logic [30:0] cfl, lim, gam, ipr;
  logic        visc;

  // cell operands
  logic [30:0] rho, snd, muv, area;
  logic        last;
  logic [31:0] mu_u, mv, mxi, myi, mxj, myj;
  logic        su, sv, sxi, syi, sxj, syj;

  // working registers
  logic [63:0] prod, t1, dot, dsq_i, dsq_j;
  logic [30:0] sri, srj, tmp, dtv, step, sx, sy;
  logic [34:0] den;
  logic [31:0] run_min;
  logic        err;

  // selections
  logic [31:0] mx_d, my_d;
  logic        s1, s2;
  logic [63:0] dsq_d, prod_sh, dsq_sum, t_sat, val, ex;
  logic [64:0] t_sum;
  logic [30:0] srv, bval, nv, own, other, kmax, coef;
  logic [33:0] own8, e_fx;
  logic [34:0] gden;
  logic [31:0] gv;
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_en;
  logic [63:0] ds_a;
  logic [34:0] ds_b;
  logic        ds_busy;
  logic [63:0] ds_res;
  logic [31:0] min_new;

  cflts_divsqrt u_divsqrt (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.ds_start),
    .sqrt_mode (cmd.op == cflts_pkg::OP_DSQ),
    .op_a      (ds_a),
    .op_b      (ds_b),
    .busy      (ds_busy),
    .res       (ds_res)
  );

  // operand selection per step
  always_comb begin
    mx_d    = cmd.dir ? mxj : mxi;
    my_d    = cmd.dir ? myj : myi;
    s1      = su ^ (cmd.dir ? sxj : sxi);
    s2      = sv ^ (cmd.dir ? syj : syi);
    dsq_d   = cmd.dir ? dsq_j : dsq_i;
    prod_sh = prod >> FRAC_BITS;
    dsq_sum = t1 + prod;
    t_sum   = {1'b0, dot} + {1'b0, prod};
    t_sat   = t_sum[64] ? '1 : t_sum[63:0];
    srv     = sat31(t_sat >> FRAC_BITS);
    bval    = sat31(prod_sh);
    nv      = sat31((prod << 1) >> FRAC_BITS);
    own     = cmd.dir ? srj : sri;
    other   = cmd.dir ? sri : srj;
    own8    = {own, 3'b000};
    gden    = 35'(own8) + 35'(other);
    gv      = (gden == '0) ? ONE_FX[31:0] : ds_res[31:0];
    kmax    = (gam > FOUR_THIRDS) ? gam : FOUR_THIRDS;
    e_fx    = 34'(ONE_FX) + {1'b0, lim, 2'b00};
    val     = prod_sh;
    ex      = (val - ONE_FX) >> 2;
    if (val <= ONE_FX) begin
      coef = '0;
    end else if (ex > 64'(lim)) begin
      coef = lim;
    end else begin
      coef = ex[30:0];
    end
    min_new = ({1'b0, step} < run_min) ? {1'b0, step} : run_min;
  end

  // shared multiplier inputs
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      cflts_pkg::OP_P1: begin
        mul_a = 34'(mu_u); mul_b = mx_d;
      end
      cflts_pkg::OP_P2: begin
        mul_a = 34'(mv); mul_b = my_d;
      end
      cflts_pkg::OP_DOT: begin
        mul_a = 34'(mx_d); mul_b = mx_d;
      end
      cflts_pkg::OP_YY: begin
        mul_a = 34'(my_d); mul_b = my_d;
      end
      cflts_pkg::OP_CR: begin
        mul_a = 34'(snd); mul_b = ds_res[31:0];
      end
      cflts_pkg::OP_VA: begin
        mul_a = 34'(kmax); mul_b = 32'(muv);
      end
      cflts_pkg::OP_VB: begin
        mul_a = 34'(bval); mul_b = 32'(ipr);
      end
      cflts_pkg::OP_VQ: begin
        mul_a = 34'(dtv); mul_b = 32'(sat31(dsq_d >> FRAC_BITS));
      end
      cflts_pkg::OP_NUM: begin
        mul_a = 34'(cfl); mul_b = 32'(area);
      end
      cflts_pkg::OP_GG: begin
        mul_a = 34'(gv); mul_b = gv;
      end
      cflts_pkg::OP_GE: begin
        mul_a = e_fx; mul_b = prod_sh[31:0];
      end
      default: mul_en = 1'b0;
    endcase
  end

  // divide/root operands
  always_comb begin
    ds_a = '0;
    ds_b = '0;
    case (cmd.op)
      cflts_pkg::OP_DSQ:  ds_a = dsq_sum;
      cflts_pkg::OP_VC: begin
        ds_a = 64'(bval) << FRAC_BITS; ds_b = 35'(rho);
      end
      cflts_pkg::OP_VN: begin
        ds_a = 64'(nv) << FRAC_BITS; ds_b = 35'(area);
      end
      cflts_pkg::OP_SDIV: begin
        ds_a = prod; ds_b = den;
      end
      cflts_pkg::OP_GDIV: begin
        ds_a = 64'(own8) << FRAC_BITS; ds_b = gden;
      end
      default: ds_a = '0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfl  <= 31'd131072;
      lim  <= '0;
      gam  <= 31'd91750;
      ipr  <= 31'd91022;
      visc <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        cflts_pkg::REG_CFL:    cfl  <= cfg_data;
        cflts_pkg::REG_SMOOTH: lim  <= cfg_data;
        cflts_pkg::REG_GAMMA:  gam  <= cfg_data;
        cflts_pkg::REG_INV_PR: ipr  <= cfg_data;
        cflts_pkg::REG_VISC:   visc <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // grid state: running minimum and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= '1;
      err     <= 1'b0;
    end else if (cmd.emit) begin
      run_min <= last ? '1 : min_new;
      err     <= err | (step == '0);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rho  <= in_data[30:0];
      mu_u <= mag32(in_data[62:31]);    su  <= in_data[62];
      mv   <= mag32(in_data[94:63]);    sv  <= in_data[94];
      snd  <= in_data[125:95];
      muv  <= in_data[156:126];
      area <= in_data[187:157];
      mxi  <= mag32(in_data[219:188]);  sxi <= in_data[219];
      myi  <= mag32(in_data[251:220]);  syi <= in_data[251];
      mxj  <= mag32(in_data[283:252]);  sxj <= in_data[283];
      myj  <= mag32(in_data[315:284]);  syj <= in_data[315];
      last <= in_last;
    end
    if (mul_en) begin
      prod <= 64'(66'(mul_a) * 66'(mul_b));
    end
    case (cmd.op)
      cflts_pkg::OP_P2, cflts_pkg::OP_YY: t1 <= prod;
      cflts_pkg::OP_DOT: begin
        if (s1 == s2) begin
          dot <= t1 + prod;
        end else begin
          dot <= (t1 > prod) ? (t1 - prod) : (prod - t1);
        end
      end
      cflts_pkg::OP_DSQ: begin
        if (cmd.dir) begin
          dsq_j <= dsq_sum;
        end else begin
          dsq_i <= dsq_sum;
        end
      end
      cflts_pkg::OP_SR: begin
        if (cmd.dir) begin
          srj <= srv;
          den <= 35'(sri) + 35'(srv);
        end else begin
          sri <= srv;
        end
      end
      cflts_pkg::OP_VC: tmp <= bval;
      cflts_pkg::OP_VD: begin
        if (rho == '0) begin
          dtv <= (tmp != '0) ? cflts_pkg::MAX31 : '0;
        end else begin
          dtv <= sat31(ds_res);
        end
      end
      cflts_pkg::OP_VN: tmp <= nv;
      cflts_pkg::OP_VR: begin
        if (area == '0) begin
          den <= den + ((tmp != '0) ? 35'(cflts_pkg::MAX31) : 35'd0);
        end else begin
          den <= den + 35'(sat31(ds_res));
        end
      end
      cflts_pkg::OP_STEP: begin
        if (den == '0) begin
          step <= (prod != '0) ? cflts_pkg::MAX31 : '0;
        end else begin
          step <= sat31(ds_res);
        end
        sx <= '0;
        sy <= '0;
      end
      cflts_pkg::OP_GC: begin
        if (cmd.dir) begin
          sy <= coef;
        end else begin
          sx <= coef;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {6'd0, (last ? min_new[30:0] : 31'd0), step, sy, sx, srj, sri};
      out_last <= last;
      out_err  <= err | (step == '0);
    end
  end

  assign sts.ds_busy   = ds_busy;
  assign sts.visc_on   = visc;
  assign sts.smooth_on = (lim != '0);

endmodule

[rtl/core/cflts_ctrl.sv]
// Controller: step sequencer and handshake control
`include "cfl_time_step_spectral_radius_defines.svh"
module cflts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  cflts_pkg::sts_t sts,
  output cflts_pkg::cmd_t cmd
);

  logic [cflts_pkg::OP_W-1:0] state, state_next, ret, ret_next;
  logic                       dir, dir_next;
  logic                       out_v;
  logic                       fin_go;

  assign fin_go   = (state == cflts_pkg::OP_FIN) && (!out_v || m_tready);
  assign s_tready = (state == cflts_pkg::OP_IDLE);
  assign m_tvalid = out_v;

  // next step
  always_comb begin
    state_next = state;
    ret_next   = ret;
    dir_next   = dir;
    case (state)
      cflts_pkg::OP_IDLE: begin
        if (s_tvalid) begin
          state_next = cflts_pkg::OP_P1;
          dir_next   = 1'b0;
        end
      end
      cflts_pkg::OP_P1:  state_next = cflts_pkg::OP_P2;
      cflts_pkg::OP_P2:  state_next = cflts_pkg::OP_DOT;
      cflts_pkg::OP_DOT: state_next = cflts_pkg::OP_YY;
      cflts_pkg::OP_YY:  state_next = cflts_pkg::OP_DSQ;
      cflts_pkg::OP_DSQ: begin
        state_next = cflts_pkg::OP_WAIT;
        ret_next   = cflts_pkg::OP_CR;
      end
      cflts_pkg::OP_WAIT: begin
        if (!sts.ds_busy) begin
          state_next = ret;
        end
      end
      cflts_pkg::OP_CR: state_next = cflts_pkg::OP_SR;
      cflts_pkg::OP_SR: begin
        if (!dir) begin
          dir_next   = 1'b1;
          state_next = cflts_pkg::OP_P1;
        end else begin
          dir_next   = 1'b0;
          state_next = sts.visc_on ? cflts_pkg::OP_VA : cflts_pkg::OP_NUM;
        end
      end
      cflts_pkg::OP_VA: state_next = cflts_pkg::OP_VB;
      cflts_pkg::OP_VB: state_next = cflts_pkg::OP_VC;
      cflts_pkg::OP_VC: begin
        state_next = cflts_pkg::OP_WAIT;
        ret_next   = cflts_pkg::OP_VD;
      end
      cflts_pkg::OP_VD: state_next = cflts_pkg::OP_VQ;
      cflts_pkg::OP_VQ: state_next = cflts_pkg::OP_VN;
      cflts_pkg::OP_VN: begin
        state_next = cflts_pkg::OP_WAIT;
        ret_next   = cflts_pkg::OP_VR;
      end
      cflts_pkg::OP_VR: begin
        if (!dir) begin
          dir_next   = 1'b1;
          state_next = cflts_pkg::OP_VQ;
        end else begin
          dir_next   = 1'b0;
          state_next = cflts_pkg::OP_NUM;
        end
      end
      cflts_pkg::OP_NUM: state_next = cflts_pkg::OP_SDIV;
      cflts_pkg::OP_SDIV: begin
        state_next = cflts_pkg::OP_WAIT;
        ret_next   = cflts_pkg::OP_STEP;
      end
      cflts_pkg::OP_STEP: begin
        state_next = sts.smooth_on ? cflts_pkg::OP_GDIV : cflts_pkg::OP_FIN;
      end
      cflts_pkg::OP_GDIV: begin
        state_next = cflts_pkg::OP_WAIT;
        ret_next   = cflts_pkg::OP_GG;
      end
      cflts_pkg::OP_GG: state_next = cflts_pkg::OP_GE;
      cflts_pkg::OP_GE: state_next = cflts_pkg::OP_GC;
      cflts_pkg::OP_GC: begin
        if (!dir) begin
          dir_next   = 1'b1;
          state_next = cflts_pkg::OP_GDIV;
        end else begin
          dir_next   = 1'b0;
          state_next = cflts_pkg::OP_FIN;
        end
      end
      cflts_pkg::OP_FIN: begin
        if (fin_go) begin
          state_next = cflts_pkg::OP_IDLE;
        end
      end
      default: state_next = cflts_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cflts_pkg::OP_IDLE;
      ret   <= cflts_pkg::OP_IDLE;
      dir   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      dir   <= dir_next;
      if (fin_go) begin
        out_v <= 1'b1;
      end else if (out_v && m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  // commands to the datapath
  always_comb begin
    cmd.op       = state;
    cmd.dir      = dir;
    cmd.load     = s_tvalid && s_tready;
    cmd.ds_start = (state inside {cflts_pkg::OP_DSQ, cflts_pkg::OP_VC, cflts_pkg::OP_VN,
                                  cflts_pkg::OP_SDIV, cflts_pkg::OP_GDIV});
    cmd.emit     = fin_go;
  end

  `CFL_ASSERT(a_start_unit_free, cmd.ds_start |-> !sts.ds_busy, "divide unit launched while busy")
  `CFL_ASSERT(a_wait_sees_busy, (state == cflts_pkg::OP_WAIT && $past(cmd.ds_start)) |-> sts.ds_busy, "unit not busy after launch")
  `CFL_ASSERT(a_accept_starts, (s_tvalid && s_tready) |=> (state == cflts_pkg::OP_P1), "item accepted but sequence not started")
  `CFL_ASSERT(a_emit_valid, cmd.emit |=> m_tvalid, "result emitted without valid")
  `CFL_ASSERT_ALWAYS(a_reset_clears, rst |=> !m_tvalid, "output valid after reset")

endmodule

[rtl/core/cfl_time_step_spectral_radius.sv]
// Top level of the CFL local time step and spectral radius block
//
// One grid cell enters on the s_ stream (s_tlast marks the last cell of a
// grid); one result per cell leaves on the m_ stream, with m_tlast set on
// the last cell's result, where the global minimum step is valid. m_tuser
// carries the sticky step error flag. Registers are written on cfg_we.
// An item is accepted only when the sequencer is idle, so a new item is
// not taken before the last one has reached the output register. The
// cost is set by the shared iterative divide/root unit, with up to six
// divides and two roots per cell, all issued one after another.
// A finished result waits in the output register; the next item is
// accepted meanwhile and its result holds in the last step until m_tready.
// Synchronous reset restores register defaults, sets the running minimum
// to all ones, clears the error flag and drops m_tvalid.
module cfl_time_step_spectral_radius #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // density, velocity_x, velocity_y, sound_speed, viscosity, cell_area,
  // i_face_x, i_face_y, j_face_x, j_face_y, zero pad
  input  logic [319:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // spectral_radius_i, spectral_radius_j, smoothing_x, smoothing_y,
  // local_step, global_min_step, zero pad
  output logic [191:0] m_tdata,
  output logic         m_tlast,
  // step_error
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_data
);

  cflts_pkg::cmd_t cmd;
  cflts_pkg::sts_t sts;

  cflts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cflts_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .out_data (m_tdata),
    .out_last (m_tlast),
    .out_err  (m_tuser)
  );

endmodule
